/* rtl/cht_pkg.sv */
// Package: shared constants and types for the chained hash table.
`timescale 1ns / 1ps
package cht_pkg;
	localparam int BUCKETS_DEF     = 16;
	localparam int CHAIN_DEPTH_DEF = 8;
	localparam int KEY_BYTES_DEF   = 8;

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_FIND   = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	// commands from controller to datapath
	typedef struct packed {
		logic load;      // capture request, start hash
		logic hash_step; // fold one key byte
		logic pick;      // register bucket index from hash
		logic fill_rd;   // read bucket fill
		logic scan_rd;   // issue slot read
		logic scan_cmp;  // compare read slot
		logic last_rd;   // read last slot for remove
		logic commit;    // perform write / fill update, form result
	} cht_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic hash_done;
		logic scan_done;
		logic hit;
	} cht_sts_t;
endpackage

/* rtl/cht_datapath.sv */
// Datapath: hash unit, bucket fill counters, slot memories and result register.
`timescale 1ns / 1ps
module cht_datapath #(
	parameter int BUCKETS     = cht_pkg::BUCKETS_DEF,
	parameter int CHAIN_DEPTH = cht_pkg::CHAIN_DEPTH_DEF,
	parameter int KEY_BYTES   = cht_pkg::KEY_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cht_pkg::cht_cmd_t    cmd,
	output cht_pkg::cht_sts_t    sts,
	input  logic [1:0]           opcode,
	input  logic [63:0]          key_chars,
	input  logic [3:0]           key_length,
	input  logic signed [31:0]   entry_value,
	output logic [1:0]           res_status,
	output logic signed [31:0]   res_value
);
	import cht_pkg::*;

	localparam int BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int CW   = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
	localparam int FW   = $clog2(CHAIN_DEPTH + 1);
	localparam int SW   = BW + CW;
	localparam int SLOTS = 1 << SW;
	localparam logic [3:0] KB = 4'(KEY_BYTES);

	// request registers
	logic [1:0]  op_q;
	logic [63:0] key_q;
	logic [3:0]  len_q;
	logic [31:0] val_q;
	logic [31:0] h_q;
	logic [3:0]  bidx_q;
	logic [BW-1:0] bkt_q;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] ptr_q;
	logic [CW-1:0] hit_q;
	logic          hit_q_v;

	// memories
	logic [63:0] mkey [SLOTS];
	logic [3:0]  mlen [SLOTS];
	logic [31:0] mval [SLOTS];
	logic [63:0] rkey_q;
	logic [3:0]  rlen_q;
	logic [31:0] rval_q;
	logic [FW-1:0] fill_mem [BUCKETS];

	logic [3:0]  len_sat;
	logic [63:0] kmask;
	logic [31:0] habs;
	logic [SW-1:0] rd_addr;
	logic [CW-1:0] rd_slot;
	logic [FW-1:0] last_idx;

	// saturate length and mask key
	always_comb begin
		len_sat = (key_length > KB) ? KB : key_length;
		for (int i = 0; i < 8; i++)
			kmask[i*8 +: 8] = (4'(i) < len_sat) ? 8'hFF : 8'h00;
	end

	assign habs = h_q[31] ? (32'd0 - h_q) : h_q;
	assign last_idx = fill_q - FW'(1);
	assign rd_slot = cmd.last_rd ? last_idx[CW-1:0] : ptr_q[CW-1:0];
	assign rd_addr = {bkt_q, rd_slot};

	assign sts.hash_done = (bidx_q >= len_q);
	assign sts.scan_done = (ptr_q >= fill_q);
	assign sts.hit       = hit_q_v;

	// request capture and hash
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= opcode;
			key_q  <= key_chars & kmask;
			len_q  <= len_sat;
			val_q  <= entry_value;
			h_q    <= '0;
			bidx_q <= '0;
		end else if (cmd.hash_step) begin
			h_q    <= (h_q << 5) - h_q + 32'(key_q[bidx_q[2:0]*8 +: 8]);
			bidx_q <= bidx_q + 4'd1;
		end
		if (cmd.pick)
			bkt_q <= BW'(habs % BUCKETS);
	end

	// fill counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUCKETS; i++)
				fill_mem[i] <= '0;
		end else if (cmd.commit) begin
			if (op_q == OP_ADD && fill_q < FW'(CHAIN_DEPTH))
				fill_mem[bkt_q] <= fill_q + FW'(1);
			else if (op_q == OP_REMOVE && hit_q_v)
				fill_mem[bkt_q] <= last_idx;
		end
	end

	// scan pointer and hit tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			ptr_q   <= '0;
			hit_q   <= '0;
			hit_q_v <= 1'b0;
		end else begin
			if (cmd.fill_rd) begin
				fill_q  <= fill_mem[bkt_q];
				ptr_q   <= '0;
				hit_q_v <= 1'b0;
			end
			if (cmd.scan_rd)
				ptr_q <= ptr_q + FW'(1);
			if (cmd.scan_cmp && !hit_q_v && rlen_q == len_q && rkey_q == key_q) begin
				hit_q_v <= 1'b1;
				hit_q   <= CW'(ptr_q - FW'(1));
				ptr_q   <= fill_q;
			end
		end
	end

	// slot memory read and write
	always_ff @(posedge clk) begin
		if (cmd.scan_rd || cmd.last_rd) begin
			rkey_q <= mkey[rd_addr];
			rlen_q <= mlen[rd_addr];
			rval_q <= mval[rd_addr];
		end
		if (cmd.commit) begin
			if (op_q == OP_ADD && fill_q < FW'(CHAIN_DEPTH)) begin
				mkey[{bkt_q, fill_q[CW-1:0]}] <= key_q;
				mlen[{bkt_q, fill_q[CW-1:0]}] <= len_q;
				mval[{bkt_q, fill_q[CW-1:0]}] <= val_q;
			end else if (op_q == OP_REMOVE && hit_q_v) begin
				mkey[{bkt_q, hit_q}] <= rkey_q;
				mlen[{bkt_q, hit_q}] <= rlen_q;
				mval[{bkt_q, hit_q}] <= rval_q;
			end
		end
	end

	// result word; on find hit, rval_q still holds the matched slot
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_status <= ST_OK;
			res_value  <= '0;
			unique case (op_q)
				OP_ADD:    if (fill_q >= FW'(CHAIN_DEPTH)) res_status <= ST_FULL;
				OP_FIND:   if (hit_q_v) res_value <= rval_q;
				           else res_status <= ST_NOT_FOUND;
				OP_REMOVE: if (!hit_q_v) res_status <= ST_NOT_FOUND;
				default:   ;
			endcase
		end
	end
endmodule

/* rtl/cht_ctrl.sv */
// Controller: sequencer for hash, bucket scan and commit.
`timescale 1ns / 1ps
module cht_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              out_stall,
	output logic              out_valid,
	input  logic [1:0]        opcode,
	input  cht_pkg::cht_sts_t sts,
	output cht_pkg::cht_cmd_t cmd
);
	import cht_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_HASH = 8'b00000010,
		S_PICK = 8'b00000100,
		S_FILL = 8'b00001000,
		S_SCAN = 8'b00010000,
		S_CMP  = 8'b00100000,
		S_LAST = 8'b01000000,
		S_COMMIT = 8'b10000000
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   op_add_q;
	logic   op_rem_q;

	assign in_stall  = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign out_valid = out_valid_q;

	// command decode
	always_comb begin
		cmd = '0;
		cmd.load      = (state_q == S_IDLE) && in_valid && !in_stall;
		cmd.hash_step = (state_q == S_HASH) && !sts.hash_done;
		cmd.pick      = (state_q == S_PICK);
		cmd.fill_rd   = (state_q == S_FILL);
		cmd.scan_rd   = (state_q == S_SCAN) && !sts.scan_done;
		cmd.scan_cmp  = (state_q == S_CMP);
		cmd.last_rd   = (state_q == S_LAST);
		cmd.commit    = (state_q == S_COMMIT);
	end

	// sequencing; remove with a hit reads the last slot before commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			op_add_q    <= 1'b0;
			op_rem_q    <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (cmd.load) begin
					op_add_q <= (opcode == OP_ADD) || (opcode == OP_NONE);
					op_rem_q <= (opcode == OP_REMOVE);
					state_q  <= S_HASH;
				end
				S_HASH: if (sts.hash_done) state_q <= S_PICK;
				S_PICK: state_q <= S_FILL;
				S_FILL: state_q <= op_add_q ? S_COMMIT : S_SCAN;
				S_SCAN: state_q <= sts.scan_done ?
					((sts.hit && op_rem_q) ? S_LAST : S_COMMIT) : S_CMP;
				S_CMP:  state_q <= S_SCAN;
				S_LAST: state_q <= S_COMMIT;
				S_COMMIT: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* rtl/chained_hash_table.sv */
// Top level: chained hash table with controller and datapath.
//  channel | signals                                      | dir
//  request | in_valid, in_stall, opcode, key_chars, ...    | in
//  result  | out_valid, out_stall, status, found_value     | out
// One request at a time: accept, hash the key a byte per step, pick the bucket
// and read its fill, then scan and compare chained entries until a hit or the
// chain's end (add and no-op skip the scan), read the last slot on a remove that
// hits, and commit. Reset clears fill counts and control only.
// A result waiting under out_stall holds off the next request.
`timescale 1ns / 1ps
module chained_hash_table #(
	parameter int BUCKETS     = cht_pkg::BUCKETS_DEF,
	parameter int CHAIN_DEPTH = cht_pkg::CHAIN_DEPTH_DEF,
	parameter int KEY_BYTES   = cht_pkg::KEY_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic [63:0]        key_chars,
	input  logic [3:0]         key_length,
	input  logic signed [31:0] entry_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [31:0] found_value
);
	import cht_pkg::*;

	cht_cmd_t cmd;
	cht_sts_t sts;

	cht_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_stall(out_stall), .out_valid(out_valid), .opcode(opcode),
		.sts(sts), .cmd(cmd)
	);

	cht_datapath #(
		.BUCKETS(BUCKETS), .CHAIN_DEPTH(CHAIN_DEPTH), .KEY_BYTES(KEY_BYTES)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .opcode(opcode),
		.key_chars(key_chars), .key_length(key_length), .entry_value(entry_value),
		.res_status(status), .res_value(found_value)
	);
endmodule
